// ----- rtl/core/ecgnd_pkg.sv -----
// ---------------------------------------------------------------------------
// ecgnd_pkg: shared types and constants for the ECG nibble delta decoder
// Channel state, per-channel decode result, marker codes and saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package ecgnd_pkg;

  // Absolute-form values on channel one that act as event markers
  localparam logic [9:0] MARK_A     = 10'd1001;
  localparam logic [9:0] MARK_B     = 10'd1002;
  localparam logic [9:0] MARK_C     = 10'd1010;
  localparam logic [9:0] MARK_LIMIT = 10'd1000;

  // Output clamp level
  localparam logic signed [15:0] CLAMP_TOP = 16'sd1000;

  // ceil(2^17 / 3): exact divide by three for magnitudes below 2^17
  localparam logic [16:0] RECIP3 = 17'd43691;

  // Code form, selected by bits 3..2 of a nibble (00 and 01 are short deltas)
  localparam logic [1:0] FORM_WIDE = 2'b10;
  localparam logic [1:0] FORM_ABS  = 2'b11;

  // One channel: two lookahead nibbles (bit 4 = consumed) and the sample line
  typedef struct packed {
    logic [4:0]         h0;
    logic [4:0]         h1;
    logic signed [15:0] d0;
    logic signed [15:0] d1;
    logic signed [15:0] d2;
    logic signed [15:0] d3;
  } chan_state_t;

  // Decode of one channel before the line shifts
  typedef struct packed {
    logic signed [15:0] d1;
    logic signed [15:0] d2;
    logic signed [15:0] d3;
    logic               used1;
    logic               used2;
    logic               mark;
    logic [9:0]         mark_val;
  } chan_dec_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_top(input logic signed [15:0] s);
    logic signed [15:0] r;
    r = (s > CLAMP_TOP) ? CLAMP_TOP : s;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ecg_nibble_delta_decoder_core.sv -----
// ---------------------------------------------------------------------------
// ecg_nibble_delta_decoder_core: two-channel ECG nibble delta decoder
// Each input beat passes through the input register, then the result register; one
// beat per cycle sustained unless out_stall holds, limited by the state update (divide-by-three multiply).
// Synchronous reset clears channel state to zero with no nibble consumed.
// ---------------------------------------------------------------------------
`default_nettype none

module ecg_nibble_delta_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_code_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_one,
  output logic signed [15:0] out_sample_two,
  output logic [7:0]         out_packed_low_one,
  output logic [7:0]         out_packed_high_nibbles,
  output logic [7:0]         out_packed_low_two
);
  import ecgnd_pkg::*;

  // Input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_take;
  logic       adv;

  // Channel state
  chan_state_t st1_r, st1_nxt;
  chan_state_t st2_r, st2_nxt;
  chan_dec_t   dec1, dec2;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] s1_r, s2_r, s1_nxt, s2_nxt;

  logic [3:0]         nib1, nib2;
  logic [9:0]         mv;
  logic               h2_zero;
  logic signed [15:0] l1_1, l1_2, l1_3;
  logic signed [15:0] l2_1, l2_2, l2_3;
  logic               u1_1, u1_2, u2_1, u2_2;

  // Handshake
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : in_valid_r);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  assign nib1 = in_byte_r[7:4];
  assign nib2 = in_byte_r[3:0];

  ecgnd_chan_dec u_dec1 (
    .st_i    (st1_r),
    .nib_i   (nib1),
    .watch_i (1'b1),
    .dec_o   (dec1)
  );

  ecgnd_chan_dec u_dec2 (
    .st_i    (st2_r),
    .nib_i   (nib2),
    .watch_i (1'b0),
    .dec_o   (dec2)
  );

  // Marker handling and line entries before shift
  always_comb begin
    mv      = dec1.mark_val;
    h2_zero = (st2_r.h0 == 5'd0) && (st2_r.h1 == 5'd0) && (nib2 == 4'd0);
    u1_1    = dec1.used1;
    u1_2    = dec1.used2;
    if (dec1.mark) begin
      if ((mv == MARK_A) || (mv == MARK_B)) begin
        l1_1 = h2_zero ? $signed({6'd0, mv}) : st1_r.d0;
      end else if (mv == MARK_C) begin
        l1_1 = $signed({6'd0, mv});
      end else begin
        l1_1 = st1_r.d0;
      end
      l1_2 = st1_r.d0;
      l1_3 = st1_r.d0;
      if ((mv == MARK_C) && (st2_r.h0[1:0] == 2'b00)) begin
        l2_1 = $signed({8'd0, st2_r.h1[3:0], nib2});
      end else begin
        l2_1 = st2_r.d0;
      end
      l2_2 = st2_r.d0;
      l2_3 = st2_r.d0;
      u2_1 = 1'b1;
      u2_2 = 1'b1;
    end else begin
      l1_1 = dec1.d1;
      l1_2 = dec1.d2;
      l1_3 = dec1.d3;
      l2_1 = dec2.d1;
      l2_2 = dec2.d2;
      l2_3 = dec2.d3;
      u2_1 = dec2.used1;
      u2_2 = dec2.used2;
    end
  end

  // Shift into next state
  always_comb begin
    st1_nxt    = st1_r;
    st2_nxt    = st2_r;
    if (adv) begin
      st1_nxt.h0 = {st1_r.h1[4] | u1_1, st1_r.h1[3:0]};
      st1_nxt.h1 = {u1_2, nib1};
      st1_nxt.d0 = l1_1;
      st1_nxt.d1 = l1_2;
      st1_nxt.d2 = l1_3;
      st1_nxt.d3 = l1_3;
      st2_nxt.h0 = {st2_r.h1[4] | u2_1, st2_r.h1[3:0]};
      st2_nxt.h1 = {u2_2, nib2};
      st2_nxt.d0 = l2_1;
      st2_nxt.d1 = l2_2;
      st2_nxt.d2 = l2_3;
      st2_nxt.d3 = l2_3;
    end
  end

  // Output select: skip past a marker entry, then clamp
  always_comb begin
    if (l1_1 > CLAMP_TOP) begin
      s1_nxt = clamp_top(l1_2);
      s2_nxt = clamp_top(l2_2);
    end else begin
      s1_nxt = clamp_top(l1_1);
      s2_nxt = clamp_top(l2_1);
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st1_r       <= '0;
      st2_r       <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st1_r       <= st1_nxt;
      st2_r       <= st2_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_code_byte;
    end
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_sample_one          = s1_r;
  assign out_sample_two          = s2_r;
  assign out_packed_low_one      = s1_r[7:0];
  assign out_packed_high_nibbles = {s1_r[11:8], s2_r[11:8]};
  assign out_packed_low_two      = s2_r[7:0];

  // Checks
  a_clamp_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (s1_r <= CLAMP_TOP) && (s2_r <= CLAMP_TOP))
    else $error("result sample above clamp level");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> in_valid_r && $stable(in_byte_r))
    else $error("held input beat lost");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st1_r) && $stable(st2_r))
    else $error("channel state changed without a beat");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv))
    else $error("result beat without a decoded input");

endmodule

`default_nettype wire

// ----- rtl/core/ecgnd_chan_dec.sv -----
// ---------------------------------------------------------------------------
// ecgnd_chan_dec: single-channel nibble decoder
// Decodes the oldest unconsumed nibble into new sample line entries and
// consumed marks; flags channel-one marker values when watch is set.
// ---------------------------------------------------------------------------
`default_nettype none

module ecgnd_chan_dec (
  input  ecgnd_pkg::chan_state_t st_i,
  input  logic [3:0]             nib_i,
  input  logic                   watch_i,
  output ecgnd_pkg::chan_dec_t   dec_o
);
  import ecgnd_pkg::*;

  logic [3:0]         code;
  logic signed [17:0] d0x;
  logic signed [2:0]  dsmall;
  logic signed [5:0]  dwide;
  logic signed [5:0]  dwide_adj;
  logic signed [5:0]  dhalf;
  logic [9:0]         abs_val;
  logic signed [17:0] diff;
  logic [16:0]        mag;
  logic [33:0]        prod;
  logic [16:0]        quo;
  logic signed [17:0] third;
  logic signed [17:0] s_small;
  logic signed [17:0] s_wide;
  logic signed [17:0] s_half;
  logic signed [17:0] s_t1;
  logic signed [17:0] s_t2;

  assign code = st_i.h0[3:0];
  assign d0x  = $signed({{2{st_i.d0[15]}}, st_i.d0});

  // Short form: 3-bit two's complement delta
  assign dsmall  = $signed(code[2:0]);
  assign s_small = d0x + $signed({{15{dsmall[2]}}, dsmall});

  // Wide form: 6-bit delta, half step truncated toward zero
  assign dwide     = $signed({code[1:0], st_i.h1[3:0]});
  assign dwide_adj = dwide + $signed({5'd0, dwide[5]});
  assign dhalf     = dwide_adj >>> 1;
  assign s_wide    = d0x + $signed({{12{dwide[5]}}, dwide});
  assign s_half    = d0x + $signed({{12{dhalf[5]}}, dhalf});

  // Absolute form: (v - d0) / 3 by reciprocal multiply on the magnitude
  assign abs_val = {code[1:0], st_i.h1[3:0], nib_i};
  assign diff    = $signed({8'd0, abs_val}) - d0x;
  assign mag     = diff[17] ? 17'((-diff)) : diff[16:0];
  assign prod    = mag * RECIP3;
  assign quo     = prod[33:17];
  assign third   = diff[17] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign s_t1    = d0x + third;
  assign s_t2    = d0x + (third <<< 1);

  // Form select
  always_comb begin
    dec_o          = '0;
    dec_o.d1       = st_i.d1;
    dec_o.d2       = st_i.d2;
    dec_o.d3       = st_i.d3;
    dec_o.mark_val = abs_val;
    if (!st_i.h0[4]) begin
      case (code[3:2])
        FORM_WIDE: begin
          dec_o.d1    = sat16(s_half);
          dec_o.d2    = sat16(s_wide);
          dec_o.used1 = 1'b1;
        end
        FORM_ABS: begin
          dec_o.used1 = 1'b1;
          dec_o.used2 = 1'b1;
          if (watch_i && (abs_val > MARK_LIMIT)) begin
            dec_o.mark = 1'b1;
          end else begin
            dec_o.d1 = sat16(s_t1);
            dec_o.d2 = sat16(s_t2);
            dec_o.d3 = $signed({6'd0, abs_val});
          end
        end
        default: begin
          dec_o.d1 = sat16(s_small);
        end
      endcase
    end
  end

endmodule

`default_nettype wire
